// ===== rtl/core/stmin_pkg.sv =====
// stmin_pkg: shared types and constants of the segment tree range-minimum block.
// No dependencies; used by stmin_engine and segment_tree_range_min.
package stmin_pkg;

	localparam int LEN_BITS  = 11;
	localparam int IDX_BITS  = 10;
	localparam int LOAD_BITS = 32;
	localparam int OUT_BITS  = 33;

	localparam logic [LEN_BITS-1:0] LEN_RESET = 11'd1024;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

	// one request beat handed from the front end to the engine
	typedef struct packed {
		req_kind_t             kind;
		logic [IDX_BITS-1:0]   idx;
		logic [LOAD_BITS-1:0]  value;
		logic [LEN_BITS-1:0]   range_low;
		logic [LEN_BITS-1:0]   range_high;
		logic                  bad_range;
	} req_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] min_plus_one;
		logic                err;
	} res_t;

endpackage

// ===== rtl/core/stmin_ram.sv =====
// stmin_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module stmin_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/stmin_engine.sv =====
// stmin_engine: tree store plus sequencer sharing one min compare for leaf
// updates and range queries, plus the post-reset clearing pass.
// Depends on stmin_pkg and stmin_ram.
module stmin_engine #(
	parameter int MAX_POSITIONS = 1024,
	parameter int VALUE_BITS    = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  stmin_pkg::req_t    req,
	output logic               res_valid,
	input  logic               res_take,
	output stmin_pkg::res_t    res
);

	localparam int AW = $clog2(2 * MAX_POSITIONS);
	localparam int NW = AW + 1;
	localparam logic [AW-1:0] LEAF_BASE = AW'(MAX_POSITIONS);
	localparam logic [AW-1:0] LAST_NODE = AW'(2 * MAX_POSITIONS - 1);
	localparam logic [AW-1:0] ROOT      = AW'(1);
	localparam logic [NW-1:0] NODE_BASE = NW'(MAX_POSITIONS);

	typedef enum logic [5:0] {
		S_CLR   = 6'b000001,
		S_IDLE  = 6'b000010,
		S_LD_UP = 6'b000100,
		S_Q_LO  = 6'b001000,
		S_Q_HI  = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t                state_q, state_d;
	logic [AW-1:0]         node_q, node_d;
	logic [VALUE_BITS-1:0] cur_q, cur_d;
	logic [VALUE_BITS-1:0] best_q, best_d;
	logic [NW-1:0]         lo_q, lo_d, hi_q, hi_d;
	logic                  pend_q, pend_d;
	logic                  err_q, err_d;

	logic                  wr_en, rd_en;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic [VALUE_BITS-1:0] wr_data, rd_data;

	logic                  use_rd;
	logic [VALUE_BITS-1:0] min_a, min_b, min_y;

	logic                  accept, in_store;
	logic [63:0]           load_ext;
	logic [VALUE_BITS-1:0] load_v;
	logic [AW-1:0]         leaf, parent;
	logic [NW-1:0]         hi_dec;
	logic [63:0]           sum_ext;

	stmin_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (2 * MAX_POSITIONS)
	) u_tree (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// shared compare unit
	assign use_rd = (state_q == S_LD_UP) || pend_q;
	assign min_a  = (state_q == S_LD_UP) ? cur_q : best_q;
	assign min_b  = use_rd ? rd_data : min_a;
	assign min_y  = (min_b < min_a) ? min_b : min_a;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign load_ext  = {32'd0, req.value};
	assign load_v    = load_ext[VALUE_BITS-1:0];
	assign in_store  = {22'd0, req.idx} < 32'(MAX_POSITIONS);
	assign leaf      = LEAF_BASE + AW'(req.idx);
	assign parent    = node_q >> 1;
	assign hi_dec    = hi_q - NW'(1);

	assign res_valid        = (state_q == S_FIN);
	assign sum_ext          = 64'(best_q) + 64'd1;
	assign res.err          = err_q;
	assign res.min_plus_one = err_q ? '0 : sum_ext[stmin_pkg::OUT_BITS-1:0];

	always_comb begin
		state_d = state_q;
		node_d  = node_q;
		cur_d   = cur_q;
		best_d  = best_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		pend_d  = 1'b0;
		err_d   = err_q;
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = '1;
		rd_en   = 1'b0;
		rd_addr = node_q;
		case (state_q)
			S_CLR: begin
				wr_en  = 1'b1;
				node_d = node_q + AW'(1);
				if (node_q == LAST_NODE) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (req.kind == stmin_pkg::REQ_LOAD) begin
						if (in_store) begin
							wr_en   = 1'b1;
							wr_addr = leaf;
							wr_data = load_v;
							rd_en   = 1'b1;
							rd_addr = leaf ^ AW'(1);
							node_d  = leaf;
							cur_d   = load_v;
							state_d = S_LD_UP;
						end
					end else begin
						lo_d    = NODE_BASE + NW'(req.range_low) - NW'(1);
						hi_d    = NODE_BASE + NW'(req.range_high);
						best_d  = '1;
						err_d   = req.bad_range;
						state_d = req.bad_range ? S_FIN : S_Q_LO;
					end
				end
			end
			S_LD_UP: begin
				wr_en   = 1'b1;
				wr_addr = parent;
				wr_data = min_y;
				cur_d   = min_y;
				node_d  = parent;
				if (parent == ROOT) begin
					state_d = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = parent ^ AW'(1);
				end
			end
			S_Q_LO: begin
				best_d = min_y;
				if (lo_q < hi_q) begin
					if (lo_q[0]) begin
						rd_en   = 1'b1;
						rd_addr = lo_q[AW-1:0];
						lo_d    = lo_q + NW'(1);
						pend_d  = 1'b1;
					end
					state_d = S_Q_HI;
				end else begin
					state_d = S_FIN;
				end
			end
			S_Q_HI: begin
				best_d = min_y;
				if (hi_q[0]) begin
					rd_en   = 1'b1;
					rd_addr = hi_dec[AW-1:0];
					pend_d  = 1'b1;
					hi_d    = hi_dec >> 1;
				end else begin
					hi_d = hi_q >> 1;
				end
				lo_d    = lo_q >> 1;
				state_d = S_Q_LO;
			end
			S_FIN: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			node_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			node_q  <= node_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		best_q <= best_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		err_q  <= err_d;
	end

endmodule

// ===== rtl/core/segment_tree_range_min.sv =====
// segment_tree_range_min: top level; length register, range check, result register.
// Depends on stmin_pkg and stmin_engine.
//
// Input channel (in_valid/in_ready) carries load and query beats. A load writes
// load_value at leaf load_index and refreshes its ancestors; it gives no result.
// A query over the 1-based inclusive range range_low..range_high returns
// minimum + 1 on the output channel (out_valid/out_ready), or range_error with
// a zero value when range_low is zero, the range is empty or it runs past
// array_length (capped at MAX_POSITIONS). Timing: one beat at a time. A load
// writes its leaf, then each ancestor in turn up to the root, one per cycle
// through the single RAM write port. A query climbs the tree from both range ends
// with at most one RAM read per cycle; a flagged query goes straight to its result.
// Reset: array_length returns to 1024, then a clearing pass writes all ones to
// the 2*MAX_POSITIONS tree entries, one per cycle; in_ready stays low meanwhile.
// cfg_wr_en/cfg_wr_data are taken at any time.
// A stalled result waits in the output register; the next beat is accepted
// meanwhile, and a following query holds its result until the register frees.
module segment_tree_range_min #(
	parameter int MAX_POSITIONS = 1024,
	parameter int VALUE_BITS    = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [stmin_pkg::LEN_BITS-1:0]     cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [stmin_pkg::IDX_BITS-1:0]     load_index,
	input  logic [stmin_pkg::LOAD_BITS-1:0]    load_value,
	input  logic [stmin_pkg::LEN_BITS-1:0]     range_low,
	input  logic [stmin_pkg::LEN_BITS-1:0]     range_high,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [stmin_pkg::OUT_BITS-1:0]     range_min_plus_one,
	output logic                               range_error
);

	localparam logic [11:0] LEN_CAP =
		(MAX_POSITIONS > 2047) ? 12'd2047 : 12'(MAX_POSITIONS);

	logic [stmin_pkg::LEN_BITS-1:0] array_length_q;
	logic [11:0]                    used;
	stmin_pkg::req_t                req;
	stmin_pkg::res_t                res;
	logic                           res_valid, res_take;
	logic                           out_valid_q;
	stmin_pkg::res_t                out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			array_length_q <= stmin_pkg::LEN_RESET;
		end else if (cfg_wr_en) begin
			array_length_q <= cfg_wr_data;
		end
	end

	assign used = ({1'b0, array_length_q} > LEN_CAP) ? LEN_CAP : {1'b0, array_length_q};

	assign req.kind       = stmin_pkg::req_kind_t'(req_type);
	assign req.idx        = load_index;
	assign req.value      = load_value;
	assign req.range_low  = range_low;
	assign req.range_high = range_high;
	assign req.bad_range  = (range_low == '0) || (range_low > range_high)
		|| ({1'b0, range_high} > used);

	stmin_engine #(
		.MAX_POSITIONS (MAX_POSITIONS),
		.VALUE_BITS    (VALUE_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid          = out_valid_q;
	assign range_min_plus_one = out_q.min_plus_one;
	assign range_error        = out_q.err;

endmodule

// ===== rtl/core/stmin_checker.sv =====
// stmin_checker: port-level assertions for segment_tree_range_min, bound to the top.
// Depends on stmin_pkg and segment_tree_range_min.
module stmin_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           req_type,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [stmin_pkg::OUT_BITS-1:0] range_min_plus_one,
	input logic                           range_error
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(range_min_plus_one)
		&& $stable(range_error))
		else $error("result beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> range_min_plus_one == '0)
		else $error("flagged result carries a value");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == stmin_pkg::REQ_QUERY) |=> !in_ready)
		else $error("ready straight after a query beat");

	// idle engine stays ready until a beat arrives
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("ready dropped without a beat");

endmodule

bind segment_tree_range_min stmin_checker u_stmin_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_ready           (in_ready),
	.req_type           (req_type),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.range_min_plus_one (range_min_plus_one),
	.range_error        (range_error)
);

// ===== tb/tb_segment_tree_range_min.sv =====
// tb_segment_tree_range_min: self-checking bench for the segment tree range-minimum block.
// Needs stmin_pkg and segment_tree_range_min. Loads and queries are predicted from a flat
// array of leaf values kept beside the block, and every result beat is checked in order.
module tb_segment_tree_range_min;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POSITIONS     = 1024;
	localparam int VALUE_WIDTH   = 32;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 400000;

	class range_min_checker;
		logic [stmin_pkg::LOAD_BITS-1:0] leaf_value [POSITIONS];
		logic [stmin_pkg::LEN_BITS-1:0]  length;
		stmin_pkg::res_t                 pending_answers [$];
		int                              mismatches;
		int                              loads;
		int                              queries;
		int                              flagged;

		function new();
			foreach (leaf_value[i]) leaf_value[i] = '1;
			length     = stmin_pkg::LEN_RESET;
			mismatches = 0;
			loads      = 0;
			queries    = 0;
			flagged    = 0;
		endfunction

		function int used_length();
			return (length > POSITIONS) ? POSITIONS : int'(length);
		endfunction

		function void set_length(logic [stmin_pkg::LEN_BITS-1:0] v);
			length = v;
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction

		function void note_beat(stmin_pkg::req_kind_t kind,
				logic [stmin_pkg::IDX_BITS-1:0] idx,
				logic [stmin_pkg::LOAD_BITS-1:0] value,
				logic [stmin_pkg::LEN_BITS-1:0] lo,
				logic [stmin_pkg::LEN_BITS-1:0] hi);
			stmin_pkg::res_t                 ans;
			logic [stmin_pkg::LOAD_BITS-1:0] best;
			if (kind == stmin_pkg::REQ_LOAD) begin
				leaf_value[idx] = value;
				loads++;
				return;
			end
			queries++;
			if (lo == 0 || lo > hi || hi > used_length()) begin
				ans.min_plus_one = '0;
				ans.err          = 1'b1;
				flagged++;
			end else begin
				best = '1;
				for (int p = int'(lo) - 1; p < int'(hi); p++)
					if (leaf_value[p] < best) best = leaf_value[p];
				ans.min_plus_one = stmin_pkg::OUT_BITS'(best) + 1'b1;
				ans.err          = 1'b0;
			end
			pending_answers.insert(pending_answers.size(), ans);
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_answer(logic [stmin_pkg::OUT_BITS-1:0] got_min, logic got_err);
			stmin_pkg::res_t want;
			if (pending_answers.size() == 0) begin
				report($sformatf("result %0h err %0b with no query outstanding",
					got_min, got_err));
				return;
			end
			want = pending_answers.pop_front();
			if (got_min !== want.min_plus_one)
				report($sformatf("range_min_plus_one %0h, want %0h",
					got_min, want.min_plus_one));
			if (got_err !== want.err)
				report($sformatf("range_error %0b, want %0b", got_err, want.err));
		endtask
	endclass

	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            cfg_wr_en   = 1'b0;
	logic [stmin_pkg::LEN_BITS-1:0]  cfg_wr_data = '0;
	logic                            in_valid    = 1'b0;
	logic                            in_ready;
	logic                            req_type    = stmin_pkg::REQ_LOAD;
	logic [stmin_pkg::IDX_BITS-1:0]  load_index  = '0;
	logic [stmin_pkg::LOAD_BITS-1:0] load_value  = '0;
	logic [stmin_pkg::LEN_BITS-1:0]  range_low   = '0;
	logic [stmin_pkg::LEN_BITS-1:0]  range_high  = '0;
	logic                            out_valid;
	logic                            out_ready   = 1'b0;
	logic [stmin_pkg::OUT_BITS-1:0]  range_min_plus_one;
	logic                            range_error;

	bit          tx_bursty       = 1'b0;
	bit          rx_bursty       = 1'b0;
	bit          calm            = 1'b0;
	bit          long_hold       = 1'b0;
	int unsigned cycle_count     = 0;
	int          length_settings = 0;

	range_min_checker rmq = new();

	segment_tree_range_min #(
		.MAX_POSITIONS(POSITIONS),
		.VALUE_BITS   (VALUE_WIDTH)
	) uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.req_type          (req_type),
		.load_index        (load_index),
		.load_value        (load_value),
		.range_low         (range_low),
		.range_high        (range_high),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.range_min_plus_one(range_min_plus_one),
		.range_error       (range_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			rmq.pending());
		$display("tb_segment_tree_range_min NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			rmq.check_answer(range_min_plus_one, range_error);
	end

	// output side: random stall bursts, plus one long hold on request
	initial begin : result_ready
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end
			if (stall == 0 && !calm && rx_bursty && $urandom_range(0, 4) == 0)
				stall = $urandom_range(1, 7);
			out_ready = (stall == 0);
			if (stall > 0) stall--;
		end
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_beat(stmin_pkg::req_kind_t kind,
			logic [stmin_pkg::IDX_BITS-1:0] idx,
			logic [stmin_pkg::LOAD_BITS-1:0] value,
			logic [stmin_pkg::LEN_BITS-1:0] lo,
			logic [stmin_pkg::LEN_BITS-1:0] hi);
		if (!calm && tx_bursty && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid   = 1'b1;
		req_type   = kind;
		load_index = idx;
		load_value = value;
		range_low  = lo;
		range_high = hi;
		do @(posedge clk); while (!in_ready);
		rmq.note_beat(kind, idx, value, lo, hi);
		@(negedge clk);
	endtask

	task automatic load(logic [stmin_pkg::IDX_BITS-1:0] idx,
			logic [stmin_pkg::LOAD_BITS-1:0] value);
		send_beat(stmin_pkg::REQ_LOAD, idx, value, stmin_pkg::LEN_BITS'($urandom),
			stmin_pkg::LEN_BITS'($urandom));
	endtask

	task automatic query(logic [stmin_pkg::LEN_BITS-1:0] lo,
			logic [stmin_pkg::LEN_BITS-1:0] hi);
		send_beat(stmin_pkg::REQ_QUERY, stmin_pkg::IDX_BITS'($urandom), $urandom, lo, hi);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (rmq.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_length(logic [stmin_pkg::LEN_BITS-1:0] v);
		drain();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = v;
		@(posedge clk);
		rmq.set_length(v);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		length_settings++;
	endtask

	task automatic random_query();
		int                             used;
		int                             r;
		logic [stmin_pkg::LEN_BITS-1:0] lo;
		logic [stmin_pkg::LEN_BITS-1:0] hi;
		used = rmq.used_length();
		r    = $urandom_range(0, 99);
		if (used == 0 || r < 8) begin
			lo = stmin_pkg::LEN_BITS'($urandom);
			hi = stmin_pkg::LEN_BITS'($urandom);
		end else if (r < 12) begin
			lo = '0;
			hi = stmin_pkg::LEN_BITS'($urandom);
		end else if (r < 16) begin
			hi = stmin_pkg::LEN_BITS'($urandom_range(0, 2046));
			lo = stmin_pkg::LEN_BITS'($urandom_range(int'(hi) + 1, 2047));
		end else if (r < 20) begin
			hi = stmin_pkg::LEN_BITS'($urandom_range(used + 1, 2047));
			lo = stmin_pkg::LEN_BITS'($urandom_range(1, int'(hi)));
		end else if (r < 25) begin
			lo = stmin_pkg::LEN_BITS'(1);
			hi = stmin_pkg::LEN_BITS'(used);
		end else begin
			lo = stmin_pkg::LEN_BITS'($urandom_range(1, used));
			hi = stmin_pkg::LEN_BITS'(int'(lo) + $urandom_range(0, 15));
			if (hi > used) hi = stmin_pkg::LEN_BITS'(used);
		end
		query(lo, hi);
	endtask

	task automatic random_phase(logic [stmin_pkg::LEN_BITS-1:0] len, int beats,
			bit with_hold);
		int                              used;
		logic [stmin_pkg::LOAD_BITS-1:0] value;
		write_length(len);
		used      = rmq.used_length();
		long_hold = with_hold;
		for (int n = 0; n < beats; n++) begin
			if (n % 50 == 0) begin
				tx_bursty = ($urandom_range(0, 9) < 7);
				rx_bursty = ($urandom_range(0, 9) < 7);
			end
			if ($urandom_range(0, 99) < 45) begin
				case ($urandom_range(0, 9))
					0: value = '0;
					1: value = '1;
					2: value = $urandom_range(0, 15);
					default: value = $urandom;
				endcase
				if (used > 0 && $urandom_range(0, 9) < 7)
					load(stmin_pkg::IDX_BITS'($urandom_range(0, used - 1)), value);
				else
					load(stmin_pkg::IDX_BITS'($urandom_range(0, POSITIONS - 1)), value);
			end else
				random_query();
		end
	endtask

	initial begin : stimulus
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// fresh tree at the reset length: every leaf reads as infinity
		query(11'd1, 11'd1024);
		query(11'd1, 11'd1);
		query(11'd1024, 11'd1024);
		load(10'd0, 32'hFFFF_FFFF);
		load(10'd1023, 32'h0);
		load(10'd512, 32'd5);
		load(10'd1, 32'h8000_0000);
		query(11'd1, 11'd1024);
		query(11'd1, 11'd1);
		query(11'd1, 11'd2);
		query(11'd2, 11'd1023);
		query(11'd1024, 11'd1024);
		query(11'd513, 11'd513);
		// empty, reversed and out-of-length ranges
		query(11'd0, 11'd5);
		query(11'd5, 11'd4);
		query(11'd1, 11'd1025);
		query(11'd2047, 11'd2047);
		query(11'd0, 11'd0);
		write_length(11'd1);
		query(11'd1, 11'd1);
		query(11'd1, 11'd2);
		load(10'd1000, 32'd3);
		// length above storage clamps to the full array
		write_length(11'd2047);
		query(11'd1001, 11'd1001);
		query(11'd1, 11'd1024);
		write_length(11'd0);
		query(11'd1, 11'd1);

		random_phase(11'd1024, 160, 1'b0);
		random_phase(11'd1, 100, 1'b0);
		random_phase(11'd2047, 160, 1'b0);
		random_phase(11'd0, 40, 1'b0);
		random_phase(stmin_pkg::LEN_BITS'($urandom_range(2, 1023)), 160, 1'b0);
		random_phase(stmin_pkg::LEN_BITS'($urandom_range(1, 2047)), 160, 1'b0);
		random_phase(11'd1024, 160, 1'b1);
		random_phase(11'd2, 100, 1'b0);
		calm = 1'b1;
		random_phase(11'd1024, 160, 1'b0);
		drain();

		$display("covered %0d loads and %0d queries (%0d flagged) over %0d length settings",
			rmq.loads, rmq.queries, rmq.flagged, length_settings);
		$display("with random idling on both sides, a %0d-cycle output hold and a calm tail",
			HOLD_CYCLES);
		if (rmq.mismatches == 0)
			$display("tb_segment_tree_range_min OK");
		else
			$display("tb_segment_tree_range_min NOT OK");
		$finish;
	end

endmodule
